// ----- hw/rtl/frs_pkg.sv -----
// ---------------------------------------------------------------------------
// Fragment read splitter package
// Shared widths, command codes and the command record passed from the front
// end through the command queue to the back end.
// ---------------------------------------------------------------------------
package frs_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 32;
    localparam int HALF_ENTRIES  = TABLE_ENTRIES / 2;
    localparam int TBL_IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // Result count limit per request.
    localparam int MAX_RESULTS   = 33;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

    // Field widths.
    localparam int WORD_W        = 32;
    localparam int ENTRY_IDX_W   = 5;
    localparam int IN_TDATA_W    = 168;
    localparam int OUT_TDATA_W   = 96;

    // Configuration port.
    localparam int  CFG_ADDR_W       = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SECOND_DISC  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CURRENT_DISC = 1'b1;

    // Input opcodes carried on tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Command queue depth.
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } t_cmd_kind;

    // word_a: fragment start or request offset.
    // word_b: fragment end (33 bits) or request length (zero extended).
    // word_c: fragment sector.
    typedef struct packed {
        t_cmd_kind              kind;
        logic [TBL_IDX_W-1:0]   idx;
        logic [WORD_W-1:0]      word_a;
        logic [WORD_W:0]        word_b;
        logic [WORD_W-1:0]      word_c;
    } t_cmd;

    typedef struct packed {
        logic [WORD_W-1:0] second_lba;
        logic [WORD_W-1:0] current_lba;
    } t_disc_cfg;

    typedef struct packed {
        logic idle;
        logic pop;
    } t_back_status;

endpackage

// ----- hw/rtl/fragment_read_splitter_core.sv -----
// ---------------------------------------------------------------------------
// Fragment read splitter
// Splits file read requests into per-fragment device pieces using a loaded
// fragment table, with an optional two-disc half-table mode.
// ---------------------------------------------------------------------------
// Timing: a table load passes through the command queue and is written when
// the back end takes it; each piece of a read goes through the match, select
// and emit states into the output register, and a miss leaves from select.
// Emit, or a miss at select, holds while the output register is stalled.
// Reset: synchronous, active low; empties the table, control state and queue.
// ---------------------------------------------------------------------------
module fragment_read_splitter_core
    import frs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [WORD_W-1:0]      i_cfg_wdata,
    // Request stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // entry_index[4:0], entry_start[36:5], entry_size[68:37],
    // entry_sector[100:69], request_offset[132:101], request_length[164:133]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic                   s_axis_tuser,
    // Piece stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // piece_length[31:0], piece_offset[63:32], piece_sector[95:64]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // miss
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast
);

    logic [WORD_W-1:0] r_second_lba;
    logic [WORD_W-1:0] r_current_lba;
    t_disc_cfg         disc_cfg;
    logic              push;
    t_cmd              push_cmd;
    t_cmd              head_cmd;
    logic              q_full;
    logic              q_empty;
    t_back_status      back_status;

    // Disc configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second_lba  <= '0;
            r_current_lba <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SECOND_DISC:  r_second_lba  <= i_cfg_wdata;
                CFG_CURRENT_DISC: r_current_lba <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign disc_cfg.second_lba  = r_second_lba;
    assign disc_cfg.current_lba = r_current_lba;

    frs_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_queue_full  (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    frs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (back_status.pop),
        .o_head_cmd (head_cmd),
        .o_full     (q_full),
        .o_empty    (q_empty)
    );

    frs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (disc_cfg),
        .i_head_cmd    (head_cmd),
        .i_queue_empty (q_empty),
        .o_status      (back_status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A miss always ends its request.
    a_miss_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("miss piece without last flag");

    // The front end never pushes into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("command pushed into full queue");

    // Commands leave the queue only when the back end is idle and one waits.
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.pop |-> back_status.idle && !q_empty)
        else $error("command popped while back end busy or queue empty");

endmodule

// ----- hw/rtl/frs_queue.sv -----
// ---------------------------------------------------------------------------
// Fragment read splitter command queue
// A short first-in first-out buffer that decouples the classifying front end
// from the splitting back end.
// ---------------------------------------------------------------------------
module frs_queue
    import frs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    input  logic i_pop,
    output t_cmd o_head_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    r_wr_ptr;
    logic [QPTR_W-1:0]    r_rd_ptr;
    logic [QPTR_W:0]      r_count;

    logic push_ok;
    logic pop_ok;

    assign o_full     = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_head_cmd = r_mem[r_rd_ptr];
    assign push_ok    = i_push && !o_full;
    assign pop_ok     = i_pop && !o_empty;

    // Storage is written without reset; only the pointers and count are control state.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/frs_front.sv -----
// ---------------------------------------------------------------------------
// Fragment read splitter front end
// Accepts input requests, drops those that produce no work, and turns the
// rest into table-load or read commands for the command queue.
// ---------------------------------------------------------------------------
module frs_front
    import frs_pkg::*;
(
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tuser,
    input  logic                   i_queue_full,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [WORD_W-1:0]      entry_start;
    logic [WORD_W-1:0]      entry_size;
    logic [WORD_W-1:0]      entry_sector;
    logic [WORD_W-1:0]      req_offset;
    logic [WORD_W-1:0]      req_length;
    logic                   accept;
    logic                   keep;

    // Unpack the request fields.
    assign entry_index  = s_axis_tdata[4:0];
    assign entry_start  = s_axis_tdata[36:5];
    assign entry_size   = s_axis_tdata[68:37];
    assign entry_sector = s_axis_tdata[100:69];
    assign req_offset   = s_axis_tdata[132:101];
    assign req_length   = s_axis_tdata[164:133];

    assign s_axis_tready = !i_queue_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Classify: loads outside the table and empty reads are dropped here.
    always_comb begin
        o_cmd = '0;
        keep  = 1'b0;
        if (s_axis_tuser == OP_LOAD) begin
            o_cmd.kind   = CMD_LOAD;
            o_cmd.idx    = TBL_IDX_W'(entry_index);
            o_cmd.word_a = entry_start;
            o_cmd.word_b = {1'b0, entry_start} + {1'b0, entry_size};
            o_cmd.word_c = entry_sector;
            keep         = (32'(entry_index) < 32'(TABLE_ENTRIES));
        end else begin
            o_cmd.kind   = CMD_READ;
            o_cmd.word_a = req_offset;
            o_cmd.word_b = {1'b0, req_length};
            keep         = (req_length != '0);
        end
    end

    assign o_push = accept && keep;

endmodule

// ----- hw/rtl/frs_back.sv -----
// ---------------------------------------------------------------------------
// Fragment read splitter back end
// Holds the fragment table, applies load commands and splits read commands
// into pieces: a registered match over the table, a priority select, then
// the piece arithmetic into the output register.
// ---------------------------------------------------------------------------
module frs_back
    import frs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_disc_cfg               i_cfg,
    input  t_cmd                    i_head_cmd,
    input  logic                    i_queue_empty,
    output t_back_status            o_status,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                    m_axis_tuser,
    output logic                    m_axis_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_SELECT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0] length;
        logic [WORD_W-1:0] offset;
        logic [WORD_W-1:0] sector;
        logic              miss;
        logic              last;
    } t_piece;

    // Fragment table.
    logic [WORD_W-1:0]        r_tbl_start  [TABLE_ENTRIES];
    logic [WORD_W:0]          r_tbl_end    [TABLE_ENTRIES];
    logic [WORD_W-1:0]        r_tbl_sector [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    t_state                   r_state,  n_state;
    logic [WORD_W:0]          r_off,    n_off;
    logic [WORD_W-1:0]        r_rem,    n_rem;
    logic [CNT_W-1:0]         r_cnt,    n_cnt;
    logic [TABLE_ENTRIES-1:0] r_hit,    n_hit;
    logic [TBL_IDX_W-1:0]     r_idx,    n_idx;
    t_piece                   r_out,    n_out;
    logic                     r_out_valid, n_out_valid;

    logic                     tbl_we;
    logic                     pop;
    logic                     can_emit;
    logic                     two_disc;
    logic                     upper_half;
    logic [TABLE_ENTRIES-1:0] window;
    logic [TABLE_ENTRIES-1:0] match_vec;
    logic                     hit_any;
    logic [TBL_IDX_W-1:0]     hit_idx;
    logic [WORD_W-1:0]        sel_start;
    logic [WORD_W:0]          sel_end;
    logic [WORD_W-1:0]        sel_sector;
    logic [WORD_W:0]          avail;
    logic [WORD_W-1:0]        piece;
    logic [WORD_W-1:0]        rem_after;
    logic [WORD_W:0]          frag_off;
    logic                     piece_last;

    // Searched window: whole table, or one half in two-disc mode.
    assign two_disc   = (i_cfg.second_lba != '0);
    assign upper_half = (i_cfg.current_lba == i_cfg.second_lba);

    always_comb begin
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
            if (!two_disc) begin
                window[e] = 1'b1;
            end else if (upper_half) begin
                window[e] = (e >= HALF_ENTRIES) && (e < 2 * HALF_ENTRIES);
            end else begin
                window[e] = (e < HALF_ENTRIES);
            end
        end
    end

    // Containment test for every entry; the fragment end is excluded.
    always_comb begin
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
            match_vec[e] = r_valid[e] && window[e]
                        && (r_off >= {1'b0, r_tbl_start[e]})
                        && (r_off < r_tbl_end[e]);
        end
    end

    // Lowest matching index wins.
    always_comb begin
        hit_idx = '0;
        for (int e = TABLE_ENTRIES - 1; e >= 0; e--) begin
            if (r_hit[e]) begin
                hit_idx = TBL_IDX_W'(e);
            end
        end
    end
    assign hit_any = (r_hit != '0);

    // Piece arithmetic on the selected fragment.
    assign sel_start  = r_tbl_start[r_idx];
    assign sel_end    = r_tbl_end[r_idx];
    assign sel_sector = r_tbl_sector[r_idx];
    assign avail      = sel_end - r_off;
    assign piece      = ({1'b0, r_rem} <= avail) ? r_rem : avail[WORD_W-1:0];
    assign rem_after  = r_rem - piece;
    assign frag_off   = r_off - {1'b0, sel_start};
    assign piece_last = (rem_after == '0) || (r_cnt >= CNT_W'(MAX_RESULTS - 1));

    assign can_emit = !r_out_valid || m_axis_tready;

    // Sequencer next state.
    always_comb begin
        n_state     = r_state;
        n_off       = r_off;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_hit       = r_hit;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        pop         = 1'b0;
        tbl_we      = 1'b0;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (!i_queue_empty) begin
                    pop = 1'b1;
                    if (i_head_cmd.kind == CMD_LOAD) begin
                        tbl_we = 1'b1;
                    end else begin
                        n_off   = {1'b0, i_head_cmd.word_a};
                        n_rem   = i_head_cmd.word_b[WORD_W-1:0];
                        n_cnt   = '0;
                        n_state = S_MATCH;
                    end
                end
            end
            S_MATCH: begin
                n_hit   = match_vec;
                n_state = S_SELECT;
            end
            S_SELECT: begin
                if (!hit_any) begin
                    if (can_emit) begin
                        n_out.length = r_rem;
                        n_out.offset = '0;
                        n_out.sector = '0;
                        n_out.miss   = 1'b1;
                        n_out.last   = 1'b1;
                        n_out_valid  = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_idx   = hit_idx;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (can_emit) begin
                    n_out.length = piece;
                    n_out.offset = frag_off[WORD_W-1:0];
                    n_out.sector = sel_sector;
                    n_out.miss   = 1'b0;
                    n_out.last   = piece_last;
                    n_out_valid  = 1'b1;
                    n_off        = r_off + {1'b0, piece};
                    n_rem        = rem_after;
                    n_cnt        = r_cnt + 1'b1;
                    n_state      = piece_last ? S_IDLE : S_MATCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
        r_off <= n_off;
        r_rem <= n_rem;
        r_hit <= n_hit;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    // Table storage; valid bits make unwritten slots behave as empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (tbl_we) begin
            r_valid[i_head_cmd.idx] <= 1'b1;
        end
        if (tbl_we) begin
            r_tbl_start[i_head_cmd.idx]  <= i_head_cmd.word_a;
            r_tbl_end[i_head_cmd.idx]    <= i_head_cmd.word_b;
            r_tbl_sector[i_head_cmd.idx] <= i_head_cmd.word_c;
        end
    end

    assign o_status.idle = (r_state == S_IDLE);
    assign o_status.pop  = pop;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.sector, r_out.offset, r_out.length};
    assign m_axis_tuser  = r_out.miss;
    assign m_axis_tlast  = r_out.last;

endmodule
